// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the julia escape-time modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Overlapping implication, sampled on clk_i, off while rst_ni is low.
`define JET_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define JET_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/jet_pkg.sv -----
// Package for the julia escape-time engine: widths, reset values, register indexes, tables.
package jet_pkg;

  // Number formats
  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 28;
  localparam int Z_W        = 32;
  localparam int ITER_W     = 16;
  localparam int STEP_W     = 31;
  localparam int RGBA_W     = 32;

  // Squared component after scaling, cross term after scaling
  localparam int SQ_W  = 2 * Z_W - 1 - FRAC_BITS;
  localparam int CR_W  = SQ_W + 2;
  localparam int INIT_SUM_W = COORD_BITS + Z_W + 1;
  localparam int SAT_W = (INIT_SUM_W > SQ_W + 3) ? INIT_SUM_W : SQ_W + 3;
  localparam int ESC_W = (SQ_W + 1 > FRAC_BITS + 3) ? SQ_W + 1 : FRAC_BITS + 3;
  localparam logic [ESC_W-1:0] FOUR = ESC_W'(1) << (FRAC_BITS + 2);

  // Brightness table
  localparam int BRIGHT_DEPTH = 256;
  localparam int BRIGHT_LOG2  = $clog2(BRIGHT_DEPTH);
  localparam int BRIGHT_FRAC  = 12;
  localparam int BRIGHT_W     = BRIGHT_FRAC + 2;
  localparam int RATIO_BITS   = 20;
  localparam int SEARCH_STEPS = BRIGHT_FRAC + 1;
  localparam int DIV_CNT_W    = $clog2(BRIGHT_LOG2 + 1);

  // Stream widths
  localparam int IN_W         = ((2 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = RGBA_W + ITER_W + 1;
  localparam int OUT_W        = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Register map
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_PIXEL_STEP = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_OFFSET_RE  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_OFFSET_IM  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_C_RE       = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_C_IM       = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_ITER_LIMIT = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_BASE_RGBA  = 3'd6;

  // Reset values
  localparam logic [STEP_W-1:0]        RST_PIXEL_STEP = 31'd1048576;
  localparam logic signed [Z_W-1:0]    RST_C_RE       = -32'sd187904819;
  localparam logic signed [Z_W-1:0]    RST_C_IM       = 32'sd72517838;
  localparam logic [ITER_W-1:0]        RST_ITER_LIMIT = 16'd100;
  localparam logic [RGBA_W-1:0]        RST_BASE_RGBA  = 32'hFFFF_FFFF;
  localparam logic [RGBA_W-1:0]        BLACK_RGBA     = 32'h0000_00FF;

  // Divider status toward the sequencer
  typedef struct packed {
    logic                   done;
    logic [BRIGHT_LOG2-1:0] quot;
  } div_status_t;

  typedef logic [BRIGHT_W-1:0] bright_lut_t [BRIGHT_DEPTH];

  // Brightness 0.1 + 1.2*t^0.6 in Q12, t = k/BRIGHT_DEPTH; root found by bisection
  function automatic bright_lut_t build_bright_lut();
    bright_lut_t lut;
    logic [63:0] r;
    logic [63:0] r3;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] p5;
    for (int k = 0; k < BRIGHT_DEPTH; k++) begin
      r  = (64'(k) << RATIO_BITS) / BRIGHT_DEPTH;
      r3 = r * r * r;
      lo = 64'd0;
      hi = 64'd1 << BRIGHT_FRAC;
      for (int s = 0; s < SEARCH_STEPS; s++) begin
        if (lo < hi) begin
          mid = (lo + hi + 64'd1) >> 1;
          p5  = mid * mid * mid * mid * mid;
          if (p5 <= r3) begin
            lo = mid;
          end else begin
            hi = mid - 64'd1;
          end
        end
      end
      lut[k] = BRIGHT_W'(((64'd1 << BRIGHT_FRAC) + 64'd12 * lo + 64'd5) / 64'd10);
    end
    return lut;
  endfunction

  localparam bright_lut_t BRIGHT_LUT = build_bright_lut();

  // Clamp a wide signed value to the signed Z_W range
  function automatic logic signed [Z_W-1:0] sat_z(input logic signed [SAT_W-1:0] v);
    logic [SAT_W-Z_W:0] top;
    top = v[SAT_W-1:Z_W-1];
    if ((&top) || !(|top)) begin
      return v[Z_W-1:0];
    end else if (v[SAT_W-1]) begin
      return {1'b1, {(Z_W-1){1'b0}}};
    end else begin
      return {1'b0, {(Z_W-1){1'b1}}};
    end
  endfunction

endpackage

// ----- hdl/julia_escape_time_pixel.sv -----
// Julia escape-time pixel engine: sequencer, coordinate/iteration datapath, result register.
// Each iteration runs three products through the one shared 32x32 multiplier plus the z update;
// shading adds a serial divide and the channel scaling steps. A limit of one skips iteration.
// The next item is taken once the result is registered.
// Reset: async active low; configuration registers return to defaults, no result pending.
`include "assert_macros.svh"

module julia_escape_time_pixel (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // x[11:0], y[23:12]
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [jet_pkg::IN_W-1:0]             s_axis_tdata,
  // rgba_out[31:0], iter_count[47:32], inside_set[48], zero pad above
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [jet_pkg::OUT_W-1:0]            m_axis_tdata,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [jet_pkg::REG_IDX_W-1:0]        cfg_index_i,
  input  logic [jet_pkg::Z_W-1:0]              cfg_data_i
);

  localparam int ST_W = 4;
  localparam logic [ST_W-1:0] ST_IDLE   = 4'd0;
  localparam logic [ST_W-1:0] ST_INIT_X = 4'd1;
  localparam logic [ST_W-1:0] ST_INIT_Y = 4'd2;
  localparam logic [ST_W-1:0] ST_INIT_Z = 4'd3;
  localparam logic [ST_W-1:0] ST_MRR    = 4'd4;
  localparam logic [ST_W-1:0] ST_MII    = 4'd5;
  localparam logic [ST_W-1:0] ST_MRI    = 4'd6;
  localparam logic [ST_W-1:0] ST_UPD    = 4'd7;
  localparam logic [ST_W-1:0] ST_DIV    = 4'd8;
  localparam logic [ST_W-1:0] ST_CH_R   = 4'd9;
  localparam logic [ST_W-1:0] ST_CH_G   = 4'd10;
  localparam logic [ST_W-1:0] ST_CH_B   = 4'd11;
  localparam logic [ST_W-1:0] ST_CH_A   = 4'd12;
  localparam logic [ST_W-1:0] ST_OUT    = 4'd13;

  localparam int PAD_W = jet_pkg::OUT_W - jet_pkg::OUT_FIELDS_W;
  localparam int CB    = jet_pkg::COORD_BITS;
  localparam int ZW    = jet_pkg::Z_W;
  localparam int SW    = jet_pkg::SAT_W;

  // Configuration registers
  logic [jet_pkg::STEP_W-1:0]    step_q;
  logic signed [ZW-1:0]          off_re_q;
  logic signed [ZW-1:0]          off_im_q;
  logic signed [ZW-1:0]          c_re_q;
  logic signed [ZW-1:0]          c_im_q;
  logic [jet_pkg::ITER_W-1:0]    limit_cfg_q;
  logic [jet_pkg::RGBA_W-1:0]    base_q;

  // Control
  logic [ST_W-1:0]               state_q;
  logic                          first_q;
  logic                          m_valid_q;

  // Datapath
  logic [CB-1:0]                 x_q;
  logic [CB-1:0]                 y_q;
  logic signed [ZW-1:0]          zr_q;
  logic signed [ZW-1:0]          zi_q;
  logic [jet_pkg::SQ_W-1:0]      re2_q;
  logic [jet_pkg::SQ_W-1:0]      im2_q;
  logic [jet_pkg::ITER_W-1:0]    n_q;
  logic [jet_pkg::ITER_W-1:0]    limit_q;
  logic [jet_pkg::BRIGHT_W-1:0]  bright_q;
  logic [7:0]                    ch_r_q;
  logic [7:0]                    ch_g_q;
  logic [jet_pkg::RGBA_W-1:0]    res_rgba_q;
  logic                          res_inside_q;
  logic [jet_pkg::RGBA_W-1:0]    m_rgba_q;
  logic [jet_pkg::ITER_W-1:0]    m_iter_q;
  logic                          m_inside_q;

  // Combinational
  logic                          accept;
  logic                          out_load;
  logic signed [ZW-1:0]          mul_a;
  logic signed [ZW-1:0]          mul_b;
  logic signed [2*ZW-1:0]        p;
  logic signed [ZW-1:0]          init_off;
  logic signed [SW-1:0]          init_sum;
  logic [jet_pkg::SQ_W-1:0]      sq_now;
  logic signed [jet_pkg::CR_W-1:0] cross_term;
  logic signed [SW-1:0]          zr_sum;
  logic signed [SW-1:0]          zi_sum;
  logic [jet_pkg::ESC_W-1:0]     mag;
  logic                          escape;
  logic [jet_pkg::ITER_W:0]      n_inc;
  logic                          at_limit;
  logic                          div_start;
  logic [7:0]                    chan_sat;
  logic [jet_pkg::ITER_W-1:0]    limit_eff;
  jet_pkg::div_status_t          div_stat;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign out_load      = (state_q == ST_OUT) && (!m_valid_q || m_axis_tready);
  assign cfg_ready_o   = 1'b1;
  assign limit_eff     = (limit_cfg_q == '0) ? jet_pkg::ITER_W'(1) : limit_cfg_q;

  // Select multiplier operands for the current step
  always_comb begin
    case (state_q)
      ST_INIT_X: begin
        mul_a = $signed({{(ZW-CB){1'b0}}, x_q});
        mul_b = $signed({1'b0, step_q});
      end
      ST_INIT_Y: begin
        mul_a = $signed({{(ZW-CB){1'b0}}, y_q});
        mul_b = $signed({1'b0, step_q});
      end
      ST_MRR: begin
        mul_a = zr_q;
        mul_b = zr_q;
      end
      ST_MII: begin
        mul_a = zi_q;
        mul_b = zi_q;
      end
      ST_MRI: begin
        mul_a = zr_q;
        mul_b = zi_q;
      end
      ST_CH_R: begin
        mul_a = $signed({{(ZW-8){1'b0}}, base_q[31:24]});
        mul_b = $signed({{(ZW-jet_pkg::BRIGHT_W){1'b0}}, bright_q});
      end
      ST_CH_G: begin
        mul_a = $signed({{(ZW-8){1'b0}}, base_q[23:16]});
        mul_b = $signed({{(ZW-jet_pkg::BRIGHT_W){1'b0}}, bright_q});
      end
      ST_CH_B: begin
        mul_a = $signed({{(ZW-8){1'b0}}, base_q[15:8]});
        mul_b = $signed({{(ZW-jet_pkg::BRIGHT_W){1'b0}}, bright_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  jet_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (p)
  );

  // Start point: scaled coordinate plus offset
  assign init_off = (state_q == ST_INIT_Y) ? off_re_q : off_im_q;
  assign init_sum = SW'(p) + SW'(init_off);

  // Squares and cross term, floored to the fixed-point grid
  assign sq_now     = jet_pkg::SQ_W'(p >>> jet_pkg::FRAC_BITS);
  assign cross_term = jet_pkg::CR_W'(p >>> (jet_pkg::FRAC_BITS - 1));
  assign zr_sum = SW'($signed({1'b0, re2_q})) - SW'($signed({1'b0, im2_q})) + SW'(c_re_q);
  assign zi_sum = SW'(cross_term) + SW'(c_im_q);

  // Escape test on the squares of the latest z
  assign mag    = jet_pkg::ESC_W'(re2_q) + jet_pkg::ESC_W'(sq_now);
  assign escape = (mag > jet_pkg::FOUR);
  assign n_inc    = {1'b0, n_q} + 1'b1;
  assign at_limit = (n_inc >= {1'b0, limit_q});

  assign div_start = (state_q == ST_MRI) && !first_q && escape;

  jet_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .num_i    (n_q),
    .den_i    (limit_q),
    .status_o (div_stat)
  );

  // Scaled channel, clamped at full scale
  assign chan_sat = (|p[2*ZW-1:jet_pkg::BRIGHT_FRAC+8]) ? 8'hFF :
                    p[jet_pkg::BRIGHT_FRAC+7:jet_pkg::BRIGHT_FRAC];

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= jet_pkg::RST_PIXEL_STEP;
      off_re_q    <= '0;
      off_im_q    <= '0;
      c_re_q      <= jet_pkg::RST_C_RE;
      c_im_q      <= jet_pkg::RST_C_IM;
      limit_cfg_q <= jet_pkg::RST_ITER_LIMIT;
      base_q      <= jet_pkg::RST_BASE_RGBA;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        jet_pkg::REG_PIXEL_STEP: step_q      <= cfg_data_i[jet_pkg::STEP_W-1:0];
        jet_pkg::REG_OFFSET_RE:  off_re_q    <= $signed(cfg_data_i);
        jet_pkg::REG_OFFSET_IM:  off_im_q    <= $signed(cfg_data_i);
        jet_pkg::REG_C_RE:       c_re_q      <= $signed(cfg_data_i);
        jet_pkg::REG_C_IM:       c_im_q      <= $signed(cfg_data_i);
        jet_pkg::REG_ITER_LIMIT: limit_cfg_q <= cfg_data_i[jet_pkg::ITER_W-1:0];
        jet_pkg::REG_BASE_RGBA:  base_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      first_q   <= 1'b1;
      m_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_INIT_X;
          end
        end
        ST_INIT_X: state_q <= ST_INIT_Y;
        ST_INIT_Y: state_q <= ST_INIT_Z;
        ST_INIT_Z: begin
          first_q <= 1'b1;
          state_q <= (limit_q == jet_pkg::ITER_W'(1)) ? ST_OUT : ST_MRR;
        end
        ST_MRR: state_q <= ST_MII;
        ST_MII: state_q <= ST_MRI;
        ST_MRI: begin
          if (first_q) begin
            state_q <= ST_UPD;
          end else if (escape) begin
            state_q <= ST_DIV;
          end else if (at_limit) begin
            state_q <= ST_OUT;
          end else begin
            state_q <= ST_UPD;
          end
        end
        ST_UPD: begin
          first_q <= 1'b0;
          state_q <= ST_MRR;
        end
        ST_DIV: begin
          if (div_stat.done) begin
            state_q <= ST_CH_R;
          end
        end
        ST_CH_R: state_q <= ST_CH_G;
        ST_CH_G: state_q <= ST_CH_B;
        ST_CH_B: state_q <= ST_CH_A;
        ST_CH_A: state_q <= ST_OUT;
        ST_OUT: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          x_q     <= s_axis_tdata[CB-1:0];
          y_q     <= s_axis_tdata[2*CB-1:CB];
          n_q     <= jet_pkg::ITER_W'(1);
          limit_q <= limit_eff;
        end
      end
      ST_INIT_Y: zr_q <= jet_pkg::sat_z(init_sum);
      ST_INIT_Z: begin
        zi_q         <= jet_pkg::sat_z(init_sum);
        res_rgba_q   <= jet_pkg::BLACK_RGBA;
        res_inside_q <= 1'b1;
      end
      ST_MII: re2_q <= sq_now;
      ST_MRI: begin
        im2_q <= sq_now;
        if (!first_q && !escape) begin
          n_q <= n_inc[jet_pkg::ITER_W-1:0];
        end
      end
      ST_UPD: begin
        zr_q <= jet_pkg::sat_z(zr_sum);
        zi_q <= jet_pkg::sat_z(zi_sum);
      end
      ST_DIV: begin
        if (div_stat.done) begin
          bright_q <= jet_pkg::BRIGHT_LUT[div_stat.quot];
        end
      end
      ST_CH_G: ch_r_q <= chan_sat;
      ST_CH_B: ch_g_q <= chan_sat;
      ST_CH_A: begin
        res_rgba_q   <= {ch_r_q, ch_g_q, chan_sat, base_q[7:0]};
        res_inside_q <= 1'b0;
      end
      ST_OUT: begin
        if (out_load) begin
          m_rgba_q   <= res_rgba_q;
          m_iter_q   <= n_q;
          m_inside_q <= res_inside_q;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{PAD_W{1'b0}}, m_inside_q, m_iter_q, m_rgba_q};

  `JET_ASSERT_IMPL(a_inside_black, m_valid_q && m_inside_q, m_rgba_q == jet_pkg::BLACK_RGBA, "inside pixel not black")
  `JET_ASSERT_IMPL(a_div_done_in_div, div_stat.done, state_q == ST_DIV, "divider done outside divide step")
  `JET_ASSERT_IMPL(a_iter_below_limit, state_q == ST_MRR || state_q == ST_MII || state_q == ST_UPD, n_q < limit_q, "iterating at or past limit")
  `JET_ASSERT_NEXT(a_n_hold_div, state_q == ST_DIV, $stable(n_q), "count changed during divide")

endmodule

// ----- hdl/jet_mul.sv -----
// Shared signed multiplier with registered product.
module jet_mul (
  input  logic                           clk_i,
  input  logic signed [jet_pkg::Z_W-1:0] a_i,
  input  logic signed [jet_pkg::Z_W-1:0] b_i,
  output logic signed [2*jet_pkg::Z_W-1:0] p_o
);

  logic signed [2*jet_pkg::Z_W-1:0] p_q;

  // Register the full-precision product
  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

// ----- hdl/jet_div.sv -----
// Bit-serial divider for the brightness index floor(n * BRIGHT_DEPTH / limit), n < limit.
`include "assert_macros.svh"

module jet_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [jet_pkg::ITER_W-1:0]   num_i,
  input  logic [jet_pkg::ITER_W-1:0]   den_i,
  output jet_pkg::div_status_t         status_o
);

  logic                              busy_q;
  logic                              done_q;
  logic [jet_pkg::DIV_CNT_W-1:0]     cnt_q;
  logic [jet_pkg::ITER_W-1:0]        rem_q;
  logic [jet_pkg::ITER_W-1:0]        den_q;
  logic [jet_pkg::BRIGHT_LOG2-1:0]   quot_q;
  logic [jet_pkg::ITER_W:0]          rem2;
  logic                              fits;

  // Shift the remainder up one bit and try the subtract
  assign rem2 = {rem_q, 1'b0};
  assign fits = (rem2 >= {1'b0, den_q});

  // Control: busy and one-cycle done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= !start_i && busy_q && (cnt_q == jet_pkg::DIV_CNT_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= jet_pkg::DIV_CNT_W'(jet_pkg::BRIGHT_LOG2);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == jet_pkg::DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Datapath: one quotient bit per cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= num_i;
      den_q  <= den_i;
      quot_q <= '0;
    end else if (busy_q) begin
      if (fits) begin
        rem_q <= jet_pkg::ITER_W'(rem2 - {1'b0, den_q});
      end else begin
        rem_q <= rem2[jet_pkg::ITER_W-1:0];
      end
      quot_q <= {quot_q[jet_pkg::BRIGHT_LOG2-2:0], fits};
    end
  end

  assign status_o.done = done_q;
  assign status_o.quot = quot_q;

  `JET_ASSERT_IMPL(a_rem_below_den, busy_q, rem_q < den_q, "divider remainder reached divisor")
  `JET_ASSERT_NEXT(a_done_clears_busy, done_q, !done_q, "divider done held longer than one cycle")

endmodule

// ----- bench/testbench.sv -----
// Self-checking stream bench for the julia escape-time pixel engine.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Write to this index must be ignored by the block
  localparam logic [jet_pkg::REG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

  localparam longint Q_MAX     = 64'sh0000_0000_7FFF_FFFF;
  localparam longint Q_MIN     = -64'sh0000_0000_8000_0000;
  localparam longint ESCAPE_R2 = 64'sd4 <<< jet_pkg::FRAC_BITS;
  localparam int     ITEMS_PER_VIEW = 290;
  localparam int     VIEW_COUNT     = 6;

  typedef struct packed {
    logic [jet_pkg::RGBA_W-1:0] rgba;
    logic [jet_pkg::ITER_W-1:0] iters;
    logic                       in_set;
  } pixel_shade_t;

  typedef enum logic [1:0] {SINK_OPEN, SINK_RANDOM, SINK_PATTERN} sink_mode_e;

  logic                          clk_i         = 1'b0;
  logic                          rst_ni        = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [jet_pkg::IN_W-1:0]      s_axis_tdata  = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [jet_pkg::OUT_W-1:0]     m_axis_tdata;
  logic                          cfg_valid_i   = 1'b0;
  logic                          cfg_ready_o;
  logic [jet_pkg::REG_IDX_W-1:0] cfg_index_i   = '0;
  logic [jet_pkg::Z_W-1:0]       cfg_data_i    = '0;

  // Shadow copy of the register file
  logic [jet_pkg::STEP_W-1:0]     step_q   = jet_pkg::RST_PIXEL_STEP;
  logic signed [jet_pkg::Z_W-1:0] off_re_q = '0;
  logic signed [jet_pkg::Z_W-1:0] off_im_q = '0;
  logic signed [jet_pkg::Z_W-1:0] c_re_q   = jet_pkg::RST_C_RE;
  logic signed [jet_pkg::Z_W-1:0] c_im_q   = jet_pkg::RST_C_IM;
  logic [jet_pkg::ITER_W-1:0]     limit_q  = jet_pkg::RST_ITER_LIMIT;
  logic [jet_pkg::RGBA_W-1:0]     base_q   = jet_pkg::RST_BASE_RGBA;

  pixel_shade_t pending_pixels[$];
  int unsigned  fail_count = 0;
  int unsigned  burst_left = 0;
  int unsigned  view_span  = 256;

  // Receiver state; long hold-offs are requested by bumping hold_requests
  sink_mode_e   sink_mode     = SINK_OPEN;
  int unsigned  sink_left     = 0;
  int unsigned  sink_tick     = 0;
  logic [15:0]  sink_mask     = '1;
  int unsigned  hold_requests = 0;
  int unsigned  hold_served   = 0;
  int unsigned  hold_len      = 0;
  int unsigned  hold_left     = 0;

  julia_escape_time_pixel dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint clamp_q428(input longint v);
    if (v > Q_MAX) return Q_MAX;
    if (v < Q_MIN) return Q_MIN;
    return v;
  endfunction

  // Gain 0.1 + 1.2*t^0.6 in Q12, root of t^3 = V^5 found by bisection
  function automatic int unsigned brightness_q12(input int unsigned k);
    logic [63:0] ratio;
    logic [63:0] cube;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    ratio = (64'(k) << 20) / 64'(jet_pkg::BRIGHT_DEPTH);
    cube  = ratio * ratio * ratio;
    lo    = 64'd0;
    hi    = 64'd4096;
    while (lo < hi) begin
      mid = (lo + hi + 64'd1) >> 1;
      if (mid * mid * mid * mid * mid <= cube) begin
        lo = mid;
      end else begin
        hi = mid - 64'd1;
      end
    end
    return 32'((64'd4096 + 64'd12 * lo + 64'd5) / 64'd10);
  endfunction

  function automatic logic [7:0] scale_channel8(input logic [7:0] ch, input int unsigned gain);
    int unsigned v;
    v = (32'(ch) * gain) >> 12;
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  // Escape-time iteration and shading for one pixel under the shadow registers
  function automatic pixel_shade_t shade_pixel(input logic [jet_pkg::COORD_BITS-1:0] px,
                                               input logic [jet_pkg::COORD_BITS-1:0] py);
    pixel_shade_t res;
    longint       zr;
    longint       zi;
    longint       re_sq;
    longint       im_sq;
    longint       cross_sum;
    int unsigned  lim;
    int unsigned  n;
    int unsigned  gain;
    bit           escaped;
    lim     = (limit_q == '0) ? 1 : 32'(limit_q);
    zr      = clamp_q428(longint'(px) * longint'(step_q) + longint'(off_re_q));
    zi      = clamp_q428(longint'(py) * longint'(step_q) + longint'(off_im_q));
    n       = 1;
    escaped = 1'b0;
    while (n < lim && !escaped) begin
      re_sq     = (zr * zr) >>> jet_pkg::FRAC_BITS;
      im_sq     = (zi * zi) >>> jet_pkg::FRAC_BITS;
      cross_sum = (zr * zi) >>> (jet_pkg::FRAC_BITS - 1);
      zr        = clamp_q428(re_sq - im_sq + longint'(c_re_q));
      zi        = clamp_q428(cross_sum + longint'(c_im_q));
      re_sq     = (zr * zr) >>> jet_pkg::FRAC_BITS;
      im_sq     = (zi * zi) >>> jet_pkg::FRAC_BITS;
      if (re_sq + im_sq > ESCAPE_R2) begin
        escaped = 1'b1;
      end else begin
        n++;
      end
    end
    res.iters = n[jet_pkg::ITER_W-1:0];
    if (!escaped) begin
      res.rgba   = jet_pkg::BLACK_RGBA;
      res.in_set = 1'b1;
    end else begin
      gain       = brightness_q12((jet_pkg::BRIGHT_DEPTH * n) / lim);
      res.rgba   = {scale_channel8(base_q[31:24], gain), scale_channel8(base_q[23:16], gain),
                    scale_channel8(base_q[15:8], gain), base_q[7:0]};
      res.in_set = 1'b0;
    end
    return res;
  endfunction

  function automatic logic [jet_pkg::Z_W-1:0] q428(input real v);
    return 32'($rtoi(v * 268435456.0));
  endfunction

  task automatic release_source();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  // Drop the source and hold until every pixel has come back
  task automatic wait_idle();
    release_source();
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Register writes only happen with the engine idle
  task automatic write_reg(input logic [jet_pkg::REG_IDX_W-1:0] idx,
                           input logic [jet_pkg::Z_W-1:0] value);
    wait_idle();
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      jet_pkg::REG_PIXEL_STEP: step_q   = value[jet_pkg::STEP_W-1:0];
      jet_pkg::REG_OFFSET_RE:  off_re_q = value;
      jet_pkg::REG_OFFSET_IM:  off_im_q = value;
      jet_pkg::REG_C_RE:       c_re_q   = value;
      jet_pkg::REG_C_IM:       c_im_q   = value;
      jet_pkg::REG_ITER_LIMIT: limit_q  = value[jet_pkg::ITER_W-1:0];
      jet_pkg::REG_BASE_RGBA:  base_q   = value;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Offer one pixel; bursts of random length separated by random gaps
  task automatic push_pixel(input logic [jet_pkg::COORD_BITS-1:0] px,
                            input logic [jet_pkg::COORD_BITS-1:0] py);
    int unsigned gap_len;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap_len    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      repeat (gap_len) begin
        @(negedge clk_i);
        s_axis_tvalid = 1'b0;
      end
    end
    burst_left--;
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = jet_pkg::IN_W'({py, px});
    do @(posedge clk_i); while (!s_axis_tready);
    pending_pixels.push_back(shade_pixel(px, py));
  endtask

  task automatic restore_defaults();
    write_reg(jet_pkg::REG_PIXEL_STEP, {1'b0, jet_pkg::RST_PIXEL_STEP});
    write_reg(jet_pkg::REG_OFFSET_RE, '0);
    write_reg(jet_pkg::REG_OFFSET_IM, '0);
    write_reg(jet_pkg::REG_C_RE, jet_pkg::RST_C_RE);
    write_reg(jet_pkg::REG_C_IM, jet_pkg::RST_C_IM);
    write_reg(jet_pkg::REG_ITER_LIMIT, {16'd0, jet_pkg::RST_ITER_LIMIT});
    write_reg(jet_pkg::REG_BASE_RGBA, jet_pkg::RST_BASE_RGBA);
  endtask

  // Corners and a few interior points under the reset settings
  task automatic test_reset_defaults();
    push_pixel(12'd0, 12'd0);
    push_pixel(12'd4095, 12'd4095);
    push_pixel(12'd4095, 12'd0);
    push_pixel(12'd0, 12'd4095);
    push_pixel(12'd128, 12'd64);
    push_pixel(12'd300, 12'd200);
  endtask

  task automatic test_special_cases();
    // zero limit behaves as a limit of one
    write_reg(jet_pkg::REG_ITER_LIMIT, '0);
    push_pixel(12'd0, 12'd0);
    // limit of one: never iterates; upper data bits are dropped
    write_reg(jet_pkg::REG_ITER_LIMIT, 32'hABCD_0001);
    push_pixel(12'd4095, 12'd4095);
    // largest limit with a quickly escaping pixel, odd base colour
    write_reg(jet_pkg::REG_ITER_LIMIT, 32'h0000_FFFF);
    write_reg(jet_pkg::REG_BASE_RGBA, 32'h00FF_00AA);
    push_pixel(12'd4095, 12'd4095);
    // zero constant: origin never moves, inside pixel stays black
    write_reg(jet_pkg::REG_C_RE, '0);
    write_reg(jet_pkg::REG_C_IM, '0);
    write_reg(jet_pkg::REG_ITER_LIMIT, 32'd40);
    write_reg(jet_pkg::REG_BASE_RGBA, 32'h1234_5678);
    push_pixel(12'd0, 12'd0);
    push_pixel(12'd300, 12'd0);
    // zero step: every pixel lands on the offset point
    write_reg(jet_pkg::REG_PIXEL_STEP, '0);
    write_reg(jet_pkg::REG_OFFSET_RE, q428(0.25));
    write_reg(jet_pkg::REG_OFFSET_IM, q428(0.5));
    write_reg(jet_pkg::REG_C_RE, jet_pkg::RST_C_RE);
    write_reg(jet_pkg::REG_C_IM, jet_pkg::RST_C_IM);
    write_reg(jet_pkg::REG_ITER_LIMIT, 32'd60);
    push_pixel(12'd4095, 12'd4095);
    push_pixel(12'd17, 12'd3000);
    // push the start point to both range ends; bit 31 of the step is dropped
    write_reg(jet_pkg::REG_PIXEL_STEP, 32'hFFFF_FFFF);
    write_reg(jet_pkg::REG_OFFSET_RE, 32'h7FFF_FFFF);
    write_reg(jet_pkg::REG_OFFSET_IM, 32'h8000_0000);
    write_reg(jet_pkg::REG_ITER_LIMIT, 32'd100);
    push_pixel(12'd4095, 12'd4095);
    push_pixel(12'd0, 12'd0);
    // black base colour
    write_reg(jet_pkg::REG_BASE_RGBA, '0);
    push_pixel(12'd4095, 12'd0);
    // write to an unmapped index changes nothing
    write_reg(REG_UNMAPPED, 32'hDEAD_BEEF);
    push_pixel(12'd0, 12'd4095);
  endtask

  // Hold the output for a long stretch so the engine stalls its input
  task automatic test_output_backpressure();
    restore_defaults();
    wait_idle();
    hold_len = 1500;
    hold_requests++;
    for (int i = 0; i < 8; i++) begin
      push_pixel(12'($urandom_range(0, 511)), 12'($urandom_range(0, 511)));
    end
  endtask

  // Frame a view around the origin, or scramble every register
  task automatic set_view(input bit wild);
    longint         step_v;
    longint         offs;
    real            cr;
    real            ci;
    if (wild) begin
      view_span = 4096;
      write_reg(jet_pkg::REG_PIXEL_STEP, $urandom);
      write_reg(jet_pkg::REG_OFFSET_RE, $urandom);
      write_reg(jet_pkg::REG_OFFSET_IM, $urandom);
      write_reg(jet_pkg::REG_C_RE, $urandom);
      write_reg(jet_pkg::REG_C_IM, $urandom);
      write_reg(jet_pkg::REG_ITER_LIMIT, {16'($urandom), 16'($urandom_range(0, 48))});
    end else begin
      view_span = $urandom_range(24, 200);
      step_v    = (64'sd3 <<< jet_pkg::FRAC_BITS) / longint'(view_span);
      step_v    = step_v + longint'($urandom_range(0, 32'(step_v / 4))) - step_v / 8;
      write_reg(jet_pkg::REG_PIXEL_STEP, {1'($urandom), 31'(step_v)});
      offs = -(step_v * longint'(view_span)) / 2
             + longint'($urandom_range(0, 1 << 25)) - 64'sd16777216;
      write_reg(jet_pkg::REG_OFFSET_RE, 32'(offs));
      offs = -(step_v * longint'(view_span)) / 2
             + longint'($urandom_range(0, 1 << 25)) - 64'sd16777216;
      write_reg(jet_pkg::REG_OFFSET_IM, 32'(offs));
      case ($urandom_range(0, 6))
        0: begin cr = -0.8;   ci = 0.156;   end
        1: begin cr = 0.285;  ci = 0.01;    end
        2: begin cr = -0.4;   ci = 0.6;     end
        3: begin cr = 0.355;  ci = 0.355;   end
        4: begin cr = -0.835; ci = -0.2321; end
        5: begin cr = -0.7;   ci = 0.27015; end
        default: begin
          cr = (real'($urandom_range(0, 2400)) - 1200.0) / 1000.0;
          ci = (real'($urandom_range(0, 2400)) - 1200.0) / 1000.0;
        end
      endcase
      write_reg(jet_pkg::REG_C_RE, q428(cr));
      write_reg(jet_pkg::REG_C_IM, q428(ci));
      write_reg(jet_pkg::REG_ITER_LIMIT, {16'($urandom), 16'($urandom_range(8, 128))});
    end
    write_reg(jet_pkg::REG_BASE_RGBA, $urandom);
    write_reg(REG_UNMAPPED, $urandom);
  endtask

  // Mostly pixels inside the framed view, some anywhere on the 12-bit grid
  task automatic test_random_views();
    logic [jet_pkg::COORD_BITS-1:0] px;
    logic [jet_pkg::COORD_BITS-1:0] py;
    for (int v = 0; v < VIEW_COUNT; v++) begin
      set_view(v == VIEW_COUNT - 1);
      for (int i = 0; i < ITEMS_PER_VIEW; i++) begin
        if (view_span >= 4096 || $urandom_range(0, 9) == 0) begin
          px = 12'($urandom);
          py = 12'($urandom);
        end else begin
          px = 12'($urandom_range(0, view_span - 1));
          py = 12'($urandom_range(0, view_span - 1));
        end
        push_pixel(px, py);
      end
    end
  endtask

  // Receiver: long hold-offs on request, otherwise free, random or patterned stalls
  always @(negedge clk_i) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = hold_len;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready = 1'b0;
    end else begin
      if (sink_left == 0) begin
        sink_left = $urandom_range(16, 240);
        sink_mode = sink_mode_e'($urandom_range(0, 2));
        sink_mask = 16'($urandom) | 16'h0001;
      end
      sink_left--;
      sink_tick++;
      case (sink_mode)
        SINK_OPEN:   m_axis_tready = 1'b1;
        SINK_RANDOM: m_axis_tready = ($urandom_range(0, 3) != 0);
        default:     m_axis_tready = sink_mask[sink_tick % 16];
      endcase
    end
  end

  // Compare each returned pixel with the oldest pending prediction
  always @(posedge clk_i) begin : check_pixels
    pixel_shade_t want_px;
    pixel_shade_t got_px;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_px.rgba   = m_axis_tdata[jet_pkg::RGBA_W-1:0];
      got_px.iters  = m_axis_tdata[jet_pkg::RGBA_W +: jet_pkg::ITER_W];
      got_px.in_set = m_axis_tdata[jet_pkg::RGBA_W + jet_pkg::ITER_W];
      if (pending_pixels.size() == 0) begin
        $error("pixel result with nothing pending: tdata %h", m_axis_tdata);
        fail_count++;
      end else begin
        want_px = pending_pixels.pop_front();
        if (got_px.rgba !== want_px.rgba) begin
          $error("rgba_out: expected %h, got %h", want_px.rgba, got_px.rgba);
          fail_count++;
        end
        if (got_px.iters !== want_px.iters) begin
          $error("iter_count: expected %0d, got %0d", want_px.iters, got_px.iters);
          fail_count++;
        end
        if (got_px.in_set !== want_px.in_set) begin
          $error("inside_set: expected %b, got %b", want_px.in_set, got_px.in_set);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #(50_000_000);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_reset_defaults();
    test_special_cases();
    test_output_backpressure();
    test_random_views();
    wait_idle();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/jet_pkg.sv
hdl/jet_mul.sv
hdl/jet_div.sv
hdl/julia_escape_time_pixel.sv
bench/testbench.sv
